// File: rtl/mm2_pkg.sv
// mm2_pkg: shared types and constants for the murmur2 hash engine.
// Holds the multiply constants, register indexes, sequencer states and the byte mask helper.
// No dependencies.
package mm2_pkg;

    localparam logic [63:0] MUL64   = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] MUL32   = 32'h5bd1e995;
    localparam int          SHIFT64 = 47;
    localparam int          SHIFT32 = 24;
    localparam int          FIN32A  = 13;
    localparam int          FIN32B  = 15;

    localparam logic [7:0] CFG_SEED = 8'd0;
    localparam logic [7:0] CFG_MODE = 8'd1;

    localparam logic [3:0] FULL_COUNT = 4'd8;
    localparam logic [3:0] WORD_COUNT = 4'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LEN,
        ST_K1,
        ST_K2,
        ST_HM,
        ST_TAIL,
        ST_FIN,
        ST_OUT
    } mm2_state_t;

    // keep the low n bytes of a word; n of 8 or more keeps all
    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) begin
                m[8*i +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

// File: rtl/murmur2_hash_engine_top.sv
// murmur2_hash_engine_top: MurmurHash64A / MurmurHash2 over a stream of 8-byte items.
// Iterative datapath around one 32x32 multiplier under a small sequencer.
// Depends on mm2_pkg.
//
//  channel   | direction | ports                                          | transfer when
//  ----------+-----------+------------------------------------------------+------------------------
//  input     | in        | s_data_bytes s_byte_count s_total_length s_last | s_valid && s_ready
//  result    | out       | m_hash_value                                   | m_valid && m_ready
//  config    | in        | cfg_index cfg_data                             | cfg_valid && cfg_ready
//
//  Steps: one 32x32 multiplier does all products. A 64-bit product is built from three
//  partial products plus the final sum, a 32-bit one from a single product. Each item is
//  accepted and dispatched, and each block, tail or final mix adds a dispatch step and
//  its multiplies; the first item of a mode 0 message also multiplies the length, and the
//  last item adds the final mix and a step to load the result register.
//  Reset: synchronous active-low aresetn; clears seed, mode, running hash, and marks the
//  next item as the start of a message.
//  Stalls: s_ready is high only while the sequencer is idle. A held result in the output
//  register does not block the next input; only a second result waits for it.
module murmur2_hash_engine_top
    import mm2_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_bytes,
    input  logic [3:0]  s_byte_count,
    input  logic [31:0] s_total_length,
    input  logic        s_last,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_value,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    mm2_state_t state_reg, state_next, disp_state;

    logic [1:0]  ph_reg, ph_next;
    logic [63:0] prod_reg;          // registered multiplier output
    logic [63:0] acc_reg, acc_next; // partial product sum, mode 0
    logic [63:0] x_reg, x_next;     // multiplier operand
    logic [63:0] h_reg, h_next;     // running hash
    logic [31:0] k_reg, k_next;     // mixed block word, mode 1
    logic [63:0] d_reg, d_next;     // item data, shifted down as words are used
    logic [3:0]  rest_reg, rest_next;
    logic [31:0] len_reg;
    logic        last_reg;
    logic        first_reg, first_next;
    logic        fin_reg, fin_next;
    logic        start_reg;         // next item opens a message
    logic [63:0] seed_reg;
    logic        mode_reg;
    logic [63:0] hash_out_reg;
    logic        m_valid_reg;

    logic        s_xfer;
    logic        in_mul;
    logic        mul_done;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] p;
    logic [31:0] p32, h32, dmask32;
    logic [63:0] dmask;
    logic [3:0]  count_sat;
    logic        out_load;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_hash_value = hash_out_reg;

    assign count_sat = (s_byte_count > FULL_COUNT) ? FULL_COUNT : s_byte_count;

    assign in_mul = (state_reg == ST_LEN) || (state_reg == ST_K1) || (state_reg == ST_K2) ||
                    (state_reg == ST_HM)  || (state_reg == ST_TAIL) || (state_reg == ST_FIN);
    assign mul_done = in_mul && (mode_reg ? (ph_reg == 2'd1) : (ph_reg == 2'd3));

    // shared multiplier: mode 0 walks lo*lo, lo*hi, hi*lo of the 64-bit product
    always_comb begin
        mul_a = x_reg[31:0];
        mul_b = mode_reg ? MUL32 : MUL64[31:0];
        if (!mode_reg) begin
            unique case (ph_reg)
                2'd1: begin
                    mul_b = MUL64[63:32];
                end
                2'd2: begin
                    mul_a = x_reg[63:32];
                end
                default: begin
                end
            endcase
        end
    end
    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    assign p   = mode_reg ? {32'b0, prod_reg[31:0]} : (acc_reg + {prod_reg[31:0], 32'b0});
    assign p32 = p[31:0];
    assign h32 = h_reg[31:0];

    assign dmask   = d_reg & byte_mask(rest_reg);
    assign dmask32 = dmask[31:0];

    // what the dispatch step starts next
    always_comb begin
        priority if (!mode_reg && first_reg) begin
            disp_state = ST_LEN;
        end else if (!mode_reg && rest_reg == FULL_COUNT) begin
            disp_state = ST_K1;
        end else if (mode_reg && rest_reg >= WORD_COUNT) begin
            disp_state = ST_K1;
        end else if (rest_reg != 4'd0) begin
            disp_state = ST_TAIL;
        end else if (last_reg && !fin_reg) begin
            disp_state = ST_FIN;
        end else if (last_reg) begin
            disp_state = ST_OUT;
        end else begin
            disp_state = ST_IDLE;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        ph_next    = 2'd0;
        if (in_mul && !mul_done) begin
            ph_next = ph_reg + 2'd1;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                state_next = disp_state;
            end
            ST_LEN, ST_HM, ST_TAIL, ST_FIN: begin
                if (mul_done) state_next = ST_DISPATCH;
            end
            ST_K1: begin
                if (mul_done) state_next = ST_K2;
            end
            ST_K2: begin
                if (mul_done) state_next = ST_HM;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath updates
    always_comb begin
        x_next     = x_reg;
        h_next     = h_reg;
        k_next     = k_reg;
        d_next     = d_reg;
        rest_next  = rest_reg;
        first_next = first_reg;
        fin_next   = fin_reg;
        acc_next   = acc_reg;
        out_load   = 1'b0;

        if (ph_reg == 2'd1) begin
            acc_next = prod_reg;
        end else if (ph_reg == 2'd2) begin
            acc_next = acc_reg + {prod_reg[31:0], 32'b0};
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    d_next     = s_data_bytes;
                    rest_next  = count_sat;
                    fin_next   = 1'b0;
                    first_next = start_reg && !mode_reg;
                    if (mode_reg) begin
                        h_next = start_reg ? {32'b0, seed_reg[31:0] ^ s_total_length}
                                           : {32'b0, h32};
                    end
                end
            end
            ST_DISPATCH: begin
                unique case (disp_state)
                    ST_LEN: begin
                        x_next = {32'b0, len_reg};
                    end
                    ST_K1: begin
                        if (mode_reg) begin
                            x_next    = {32'b0, d_reg[31:0]};
                            d_next    = {32'b0, d_reg[63:32]};
                            rest_next = rest_reg - WORD_COUNT;
                        end else begin
                            x_next    = d_reg;
                            rest_next = 4'd0;
                        end
                    end
                    ST_TAIL: begin
                        x_next    = mode_reg ? {32'b0, h32 ^ dmask32} : (h_reg ^ dmask);
                        rest_next = 4'd0;
                    end
                    ST_FIN: begin
                        x_next = mode_reg ? {32'b0, h32 ^ (h32 >> FIN32A)}
                                          : (h_reg ^ (h_reg >> SHIFT64));
                    end
                    default: begin
                    end
                endcase
            end
            ST_LEN: begin
                if (mul_done) begin
                    h_next     = seed_reg ^ p;
                    first_next = 1'b0;
                end
            end
            ST_K1: begin
                if (mul_done) begin
                    x_next = mode_reg ? {32'b0, p32 ^ (p32 >> SHIFT32)} : (p ^ (p >> SHIFT64));
                end
            end
            ST_K2: begin
                if (mul_done) begin
                    if (mode_reg) begin
                        k_next = p32;
                        x_next = {32'b0, h32};
                    end else begin
                        x_next = h_reg ^ p;
                    end
                end
            end
            ST_HM: begin
                if (mul_done) begin
                    h_next = mode_reg ? {32'b0, p32 ^ k_reg} : p;
                end
            end
            ST_TAIL: begin
                if (mul_done) begin
                    h_next = p;
                end
            end
            ST_FIN: begin
                if (mul_done) begin
                    fin_next = 1'b1;
                    h_next   = mode_reg ? {32'b0, p32 ^ (p32 >> FIN32B)} : (p ^ (p >> SHIFT64));
                end
            end
            ST_OUT: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ph_reg      <= 2'd0;
            start_reg   <= 1'b1;
            first_reg   <= 1'b0;
            fin_reg     <= 1'b0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            seed_reg    <= '0;
            mode_reg    <= 1'b0;
            h_reg       <= '0;
        end else begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            first_reg <= first_next;
            fin_reg   <= fin_next;
            h_reg     <= h_next;
            if (s_xfer) begin
                start_reg <= s_last;
                last_reg  <= s_last;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SEED) seed_reg <= cfg_data;
                if (cfg_index == CFG_MODE) mode_reg <= cfg_data[0];
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        k_reg    <= k_next;
        d_reg    <= d_next;
        rest_reg <= rest_next;
        if (s_xfer) len_reg <= s_total_length;
        if (out_load) hash_out_reg <= h_reg;
    end

    // checks
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (state_reg == ST_DISPATCH) && !s_ready)
        else $error("accepted item did not start the sequencer");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_fin_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_reg |-> last_reg)
        else $error("final mix on an item not marked last");

    a_rest_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (rest_reg <= FULL_COUNT))
        else $error("byte count out of range");

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg)
        else $error("held result dropped");

endmodule

// File: tb/murmur2_tb_pkg.sv
`timescale 1ns / 100ps
// murmur2_tb_pkg: hash mode codes shared by the stimulus top and the checker.
// No dependencies.
package murmur2_tb_pkg;

    typedef enum logic {
        HASH64A = 1'b0,
        HASH32  = 1'b1
    } hash_mode_t;

endpackage

// File: tb/murmur2_hash_checker.sv
`timescale 1ns / 100ps
// murmur2_hash_checker: watches the input, result and register channels of the hash engine,
// predicts each message hash and compares it with the result transfers.
// Depends on mm2_pkg (constants, register indexes) and murmur2_tb_pkg (mode codes).
module murmur2_hash_checker
    import mm2_pkg::*;
    import murmur2_tb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [63:0] s_data_bytes,
    input  logic [3:0]  s_byte_count,
    input  logic [31:0] s_total_length,
    input  logic        s_last,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_hash_value,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data,

    input  logic        end_of_test,
    output int          outstanding,
    output int          fail_count,
    output int          results_checked
);

    logic [63:0] seed_reg;
    hash_mode_t  mode_reg;
    logic [63:0] running_hash;
    logic        msg_start;
    logic [63:0] expected_hashes[$];
    int          errors   = 0;
    int          checked  = 0;
    logic        end_seen = 1'b0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic logic [63:0] keep_bytes(input logic [63:0] v, input int n);
        if (n >= 8) begin
            return v;
        end
        return v & ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function automatic logic [63:0] mix_block64(input logic [63:0] h, input logic [63:0] k);
        logic [63:0] kk;
        kk = k * MUL64;
        kk = kk ^ (kk >> SHIFT64);
        kk = kk * MUL64;
        return (h ^ kk) * MUL64;
    endfunction

    function automatic logic [31:0] mix_block32(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] kk;
        kk = k * MUL32;
        kk = kk ^ (kk >> SHIFT32);
        kk = kk * MUL32;
        return (h * MUL32) ^ kk;
    endfunction

    // running hash after one item, under the current seed and mode
    function automatic logic [63:0] fold_item(input logic [63:0] h_prev, input logic opening,
                                              input logic [63:0] data, input logic [3:0] cnt,
                                              input logic [31:0] len, input logic closing);
        logic [63:0] h;
        logic [63:0] d;
        logic [31:0] h32;
        int          n;
        n = (int'(cnt) > 8) ? 8 : int'(cnt);
        if (mode_reg == HASH64A) begin
            h = opening ? (seed_reg ^ ({32'h0, len} * MUL64)) : h_prev;
            if (n == 8) begin
                h = mix_block64(h, data);
            end else if (n > 0) begin
                h = (h ^ keep_bytes(data, n)) * MUL64;
            end
            if (closing) begin
                h = h ^ (h >> SHIFT64);
                h = h * MUL64;
                h = h ^ (h >> SHIFT64);
            end
            return h;
        end
        h32 = opening ? (seed_reg[31:0] ^ len) : h_prev[31:0];
        d   = data;
        if (n >= 4) begin
            h32 = mix_block32(h32, d[31:0]);
            d   = d >> 32;
            n   = n - 4;
        end
        if (n >= 4) begin
            h32 = mix_block32(h32, d[31:0]);
            n   = n - 4;
        end
        if (n > 0) begin
            h32 = (h32 ^ 32'(keep_bytes(d, n))) * MUL32;
        end
        if (closing) begin
            h32 = h32 ^ (h32 >> FIN32A);
            h32 = h32 * MUL32;
            h32 = h32 ^ (h32 >> FIN32B);
        end
        return {32'h0, h32};
    endfunction

    always @(posedge aclk) begin : monitor
        logic [63:0] want;
        if (!aresetn) begin
            seed_reg     = '0;
            mode_reg     = HASH64A;
            running_hash = '0;
            msg_start    = 1'b1;
            expected_hashes.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SEED) begin
                    seed_reg = cfg_data;
                end else if (cfg_index == CFG_MODE) begin
                    mode_reg = hash_mode_t'(cfg_data[0]);
                end
            end
            // results first, so an early result never pairs with this edge's item
            if (m_valid && m_ready) begin
                if (expected_hashes.size() == 0) begin
                    report_mismatch("result with nothing expected", m_hash_value, '0);
                end else begin
                    want = expected_hashes.pop_front();
                    checked++;
                    if (m_hash_value !== want) begin
                        report_mismatch("hash_value", m_hash_value, want);
                    end
                end
            end
            if (s_valid && s_ready) begin
                running_hash = fold_item(running_hash, msg_start, s_data_bytes, s_byte_count,
                                         s_total_length, s_last);
                msg_start = s_last;
                if (s_last) begin
                    expected_hashes.push_back(running_hash);
                end
            end
            if (end_of_test && !end_seen) begin
                end_seen = 1'b1;
                if (expected_hashes.size() != 0) begin
                    report_mismatch("hashes still expected at end",
                                    64'(expected_hashes.size()), '0);
                end
            end
        end
        outstanding     <= expected_hashes.size();
        fail_count      <= errors;
        results_checked <= checked;
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// testbench: stimulus and verdict for murmur2_hash_engine_top, with the checker beside it.
// Depends on mm2_pkg, murmur2_tb_pkg, murmur2_hash_checker and the engine RTL.
module testbench;
    import mm2_pkg::*;
    import murmur2_tb_pkg::*;

    localparam int CLK_HALF      = 5;      // 10 ns period
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 64;
    localparam int WATCHDOG_MAX  = 2000;   // cycles with no transfer on any channel
    localparam int MAX_WAIT      = 19;     // longest sender gap / receiver stall
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 125;    // ~1000 random items in all

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [63:0] s_data_bytes   = '0;
    logic [3:0]  s_byte_count   = '0;
    logic [31:0] s_total_length = '0;
    logic        s_last         = 1'b0;

    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [63:0] m_hash_value;

    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index      = '0;
    logic [63:0] cfg_data       = '0;

    logic        end_of_test    = 1'b0;
    int          outstanding;
    int          fail_count;
    int          results_checked;

    // quiet phases: no gaps on the sender, no stalls on the receiver
    logic        quiet          = 1'b0;

    int          items_sent     = 0;
    int          messages_sent  = 0;
    int          settings_used  = 0;
    int unsigned idle_cycles    = 0;

    always #(CLK_HALF) aclk = ~aclk;

    murmur2_hash_engine_top u_top (.*);

    murmur2_hash_checker u_checker (.*);

    // ------------------------------------------------------------------
    // Result side: once a result shows up, hold off for a drawn number of
    // cycles, then take it. After a transfer, ready sometimes stays high
    // so the next result can go through on its first cycle.
    // ------------------------------------------------------------------
    logic stalling  = 1'b0;
    int   stall_left = 0;

    always @(posedge aclk) begin : result_sink
        int draw;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            stalling <= 1'b0;
        end else if (m_valid && m_ready) begin
            m_ready <= quiet || ($urandom_range(0, 3) == 0);
        end else if (m_valid && !m_ready) begin
            if (!stalling) begin
                draw = quiet ? 0 : $urandom_range(0, MAX_WAIT);
                if (draw == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    stalling   <= 1'b1;
                    stall_left <= draw - 1;
                end
            end else if (stall_left == 0) begin
                m_ready  <= 1'b1;
                stalling <= 1'b0;
            end else begin
                stall_left <= stall_left - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a long run of cycles with no transfer anywhere means a hang.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("Watchdog: no transfer for %0d cycles, %0d hashes outstanding",
                         idle_cycles, outstanding);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // One input transfer. A gap of zero keeps valid high straight into the
    // next item; otherwise valid drops for the gap. Returns at the edge of
    // the transfer, leaving valid high.
    task automatic send_item(input logic [63:0] data, input logic [3:0] cnt,
                             input logic [31:0] len, input logic is_last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data_bytes   <= data;
        s_byte_count   <= cnt;
        s_total_length <= len;
        s_last         <= is_last;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (is_last) begin
            messages_sent++;
        end
    endtask

    // Drop valid and wait until every hash is in, then give the engine time
    // to finish an item that has no result of its own.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Seed then mode, back to back on the register channel. Only called with
    // the engine idle.
    task automatic apply_settings(input logic [63:0] seed, input hash_mode_t mode);
        cfg_index <= CFG_SEED;
        cfg_data  <= seed;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_MODE;
        cfg_data  <= 64'(mode);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly well-formed messages: full items, then a last item with 0..8
    // bytes and a matching length. The rest is noise: any byte count, any
    // length, partial items in the middle.
    task automatic send_random_message();
        int          full_items;
        int          tail_count;
        int          pieces;
        logic [31:0] len;
        if ($urandom_range(0, 99) < 85) begin
            full_items = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16)
                                                     : $urandom_range(0, 4);
            tail_count = $urandom_range(0, 8);
            len = 32'(8 * full_items + tail_count);
            for (int i = 0; i < full_items; i++) begin
                send_item({$urandom, $urandom}, FULL_COUNT, len, 1'b0);
            end
            send_item({$urandom, $urandom}, 4'(tail_count), len, 1'b1);
        end else begin
            pieces = $urandom_range(1, 4);
            for (int i = 0; i < pieces; i++) begin
                send_item({$urandom, $urandom}, 4'($urandom_range(0, 15)), $urandom,
                          i == pieces - 1);
            end
        end
    endtask

    initial begin : stimulus
        int          phase_start;
        logic [63:0] seed;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed: reset values (seed 0, 64-bit mode) ---
        send_item({$urandom, $urandom}, 4'd0, 32'd0, 1'b1);          // empty message
        send_item('1, FULL_COUNT, 32'hffff_ffff, 1'b0);               // max length
        send_item('0, 4'd15, 32'hffff_ffff, 1'b1);                   // count saturates to 8
        settle();

        // --- directed: 64-bit mode, all-ones seed, partial items ---
        apply_settings('1, HASH64A);
        for (int n = 1; n < 8; n += 2) begin
            // bytes above the count are all ones and must be ignored
            send_item('1, 4'(n), 32'(n), 1'b1);
        end
        send_item(64'h0123_4567_89ab_cdef, 4'd2, 32'd10, 1'b0);      // partial, not last
        send_item(64'hfedc_ba98_7654_3210, FULL_COUNT, 32'd10, 1'b1);
        settle();

        // --- directed: 32-bit mode, upper seed bits must not matter ---
        apply_settings(64'h1234_5678_ffff_ffff, HASH32);
        send_item('1, FULL_COUNT, 32'hffff_ffff, 1'b1);
        send_item('1, 4'd2, 32'd2, 1'b1);                           // tail only
        send_item('1, 4'd4, 32'd4, 1'b1);                           // one word, no tail
        send_item('1, 4'd6, 32'd6, 1'b1);                           // word plus tail
        send_item(64'h8000_0001_8000_0001, 4'd9, 32'd8, 1'b1);      // saturates
        send_item('0, 4'd0, 32'd0, 1'b1);
        send_item({$urandom, $urandom}, 4'd6, 32'd6, 1'b0);         // partial mid-message
        send_item({$urandom, $urandom}, 4'd0, 32'd6, 1'b1);
        settle();

        // --- directed: mode flips inside a message ---
        apply_settings(64'hdead_beef_cafe_f00d, HASH64A);
        send_item({$urandom, $urandom}, FULL_COUNT, 32'd21, 1'b0);
        settle();
        apply_settings(64'hdead_beef_cafe_f00d, HASH32);             // 32-bit middle
        send_item({$urandom, $urandom}, FULL_COUNT, 32'd21, 1'b0);
        settle();
        apply_settings(64'hdead_beef_cafe_f00d, HASH64A);
        send_item({$urandom, $urandom}, 4'd5, 32'd21, 1'b1);
        settle();
        apply_settings(64'h0, HASH32);
        send_item({$urandom, $urandom}, 4'd7, 32'd15, 1'b0);
        settle();
        apply_settings(64'h0, HASH64A);
        send_item({$urandom, $urandom}, FULL_COUNT, 32'd15, 1'b1);
        settle();

        // --- random phases, each with fresh settings ---
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       seed = '0;
                1:       seed = '1;
                2:       seed = 64'h0000_0000_ffff_ffff;
                default: seed = {$urandom, $urandom};
            endcase
            apply_settings(seed, hash_mode_t'(p % 2));
            quiet <= (p == 5);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                send_random_message();
            end
            settle();
        end

        end_of_test <= 1'b1;
        repeat (2) @(posedge aclk);
        $display("Run covered %0d input transfers in %0d messages over %0d register settings",
                 items_sent, messages_sent, settings_used);
        $display("%0d hashes compared, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/mm2_pkg.sv
rtl/murmur2_hash_engine_top.sv
tb/murmur2_tb_pkg.sv
tb/murmur2_hash_checker.sv
tb/testbench.sv
